// ===== sv/pds_pkg.sv =====
// ----------------------------------------------------------------------------
// pds_pkg
// Shared types, codes and constants of the power-domain sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pds_pkg;

  // Field widths of the command and response items
  localparam int CmdW      = 2;
  localparam int DomW      = 2;
  localparam int UserMaskW = 8;
  localparam int SenseW    = 8;
  localparam int StatusW   = 2;
  localparam int DomMaskW  = 4;
  localparam int DomSlots  = 1 << DomW;

  // Board shape
  localparam int NumDomains     = 4;
  localparam int SensePerDomain = 2;
  localparam int UserBits       = 8;

  // Configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 10;
  localparam int CntW     = 10;
  localparam int TickW    = 8;

  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

  // Reset values of the configuration registers
  localparam logic [DomMaskW-1:0] DomainPresentRst = 4'd15;
  localparam logic [SenseW-1:0]   SensePresentRst  = 8'd0;
  localparam logic [SenseW-1:0]   SenseUpLevelRst  = 8'd255;
  localparam logic [TickW-1:0]    SettleTicksRst   = 8'd15;
  localparam logic [TickW-1:0]    PollTicksRst     = 8'd5;
  localparam logic [CntW-1:0]     TimeoutTicksRst  = 10'd50;
  localparam logic                AuxDropParksKRst = 1'b0;

  localparam logic [DomW-1:0] DomAux = 2'd0;
  localparam logic [DomW-1:0] DomK   = 2'd3;

  typedef enum logic [CmdW-1:0] {
    CMD_REQUEST = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_TICK    = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK   = 2'd0,
    ST_FAIL = 2'd1,
    ST_BUSY = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DOMAIN_PRESENT   = 3'd0,
    CFG_SENSE_PRESENT    = 3'd1,
    CFG_SENSE_UP_LEVEL   = 3'd2,
    CFG_SETTLE_TICKS     = 3'd3,
    CFG_POLL_TICKS       = 3'd4,
    CFG_TIMEOUT_TICKS    = 3'd5,
    CFG_AUX_DROP_PARKS_K = 3'd6
  } cfg_reg_e;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_SETTLE = 3'b010,
    PH_POLL   = 3'b100
  } phase_e;

  // Sense line bits that belong to domain d (bits past the vector are absent)
  function automatic logic [SenseW-1:0] sense_mask(logic [DomW-1:0] d);
    logic [SenseW-1:0] m;
    int                b;
    m = '0;
    for (int s = 0; s < SensePerDomain; s++) begin
      b = int'(d) * SensePerDomain + s;
      if (b < SenseW) m[b % SenseW] = 1'b1;
    end
    return m;
  endfunction

endpackage

// ===== sv/pds_if.sv =====
// ----------------------------------------------------------------------------
// pds_cmd_if / pds_rsp_if
// Valid/ready channels for sequencer commands and responses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pds_cmd_if;
  logic                           valid;
  logic                           ready;
  logic [pds_pkg::CmdW-1:0]       cmd;
  logic [pds_pkg::DomW-1:0]       domain;
  logic [pds_pkg::UserMaskW-1:0]  user_mask;
  logic [pds_pkg::SenseW-1:0]     sense_levels;

  modport source (output valid, cmd, domain, user_mask, sense_levels, input ready);
  modport sink   (input valid, cmd, domain, user_mask, sense_levels, output ready);
endinterface

interface pds_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [pds_pkg::StatusW-1:0]   status;
  logic [pds_pkg::DomW-1:0]      done_domain;
  logic [pds_pkg::DomMaskW-1:0]  enable_mask;
  logic [pds_pkg::DomMaskW-1:0]  released_mask;
  logic [pds_pkg::DomMaskW-1:0]  on_mask;
  logic                          fault_alert;

  modport source (output valid, status, done_domain, enable_mask, released_mask, on_mask,
                  fault_alert, input ready);
  modport sink   (input valid, status, done_domain, enable_mask, released_mask, on_mask,
                  fault_alert, output ready);
endinterface

// ===== sv/power_domain_sequencer.sv =====
// ----------------------------------------------------------------------------
// power_domain_sequencer
// Reference-counted power-up/power-down sequencer for four switched rails.
//
// Commands (request, release, millisecond tick) arrive on a valid/ready
// channel; each one is registered, then handled against the domain state,
// and any response lands in an output register. Throughput is one command
// per clock: the input register drains whenever the output register is
// empty or its response is taken in the same cycle, so a stalled response
// costs at most the one held command. A transferred command passes the
// input register, and any response loads the response register when it is
// handled. A request from the first user of a domain raises enable, releases
// its pins and answers only when a later tick (or the request itself, with
// zero settle time) finds the rail up or the timeout exhausted; requests and
// releases in between answer busy. Ticks answer only when they end a
// sequence. Configuration writes take effect on the next cycle and are
// expected only while no command is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module power_domain_sequencer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pds_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [pds_pkg::CfgDataW-1:0]  cfg_wdata_i,
  pds_cmd_if.sink                       cmd_ch_i,
  pds_rsp_if.source                     rsp_ch_o
);

  localparam int DomW     = pds_pkg::DomW;
  localparam int DomSlots = pds_pkg::DomSlots;
  localparam int MaskW    = pds_pkg::DomMaskW;
  localparam int UserW    = pds_pkg::UserBits;
  localparam int CntW     = pds_pkg::CntW;
  localparam int TickW    = pds_pkg::TickW;
  localparam int SenseW   = pds_pkg::SenseW;
  localparam int PortUW   = pds_pkg::UserMaskW;

  // ---------------- configuration registers ----------------
  logic [MaskW-1:0]  domain_present_q;
  logic [SenseW-1:0] sense_present_q, sense_up_level_q;
  logic [TickW-1:0]  settle_ticks_q, poll_ticks_q;
  logic [CntW-1:0]   timeout_ticks_q;
  logic              aux_drop_parks_k_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      domain_present_q   <= pds_pkg::DomainPresentRst;
      sense_present_q    <= pds_pkg::SensePresentRst;
      sense_up_level_q   <= pds_pkg::SenseUpLevelRst;
      settle_ticks_q     <= pds_pkg::SettleTicksRst;
      poll_ticks_q       <= pds_pkg::PollTicksRst;
      timeout_ticks_q    <= pds_pkg::TimeoutTicksRst;
      aux_drop_parks_k_q <= pds_pkg::AuxDropParksKRst;
    end else if (cfg_we_i) begin
      case (pds_pkg::cfg_reg_e'(cfg_idx_i))
        pds_pkg::CFG_DOMAIN_PRESENT:   domain_present_q   <= cfg_wdata_i[MaskW-1:0];
        pds_pkg::CFG_SENSE_PRESENT:    sense_present_q    <= cfg_wdata_i[SenseW-1:0];
        pds_pkg::CFG_SENSE_UP_LEVEL:   sense_up_level_q   <= cfg_wdata_i[SenseW-1:0];
        pds_pkg::CFG_SETTLE_TICKS:     settle_ticks_q     <= cfg_wdata_i[TickW-1:0];
        pds_pkg::CFG_POLL_TICKS:       poll_ticks_q       <= cfg_wdata_i[TickW-1:0];
        pds_pkg::CFG_TIMEOUT_TICKS:    timeout_ticks_q    <= cfg_wdata_i[CntW-1:0];
        pds_pkg::CFG_AUX_DROP_PARKS_K: aux_drop_parks_k_q <= cfg_wdata_i[0];
        default: ;  // unmapped index: dropped
      endcase
    end
  end

  // ---------------- input register ----------------
  logic                      in_v_q;
  logic [pds_pkg::CmdW-1:0]  cmd_q;
  logic [DomW-1:0]           dom_q;
  logic [PortUW-1:0]         user_mask_q;
  logic [SenseW-1:0]         levels_q;
  logic                      fire;      // registered command handled this cycle
  logic                      out_v_q;

  assign fire            = in_v_q && (!out_v_q || rsp_ch_o.ready);
  assign cmd_ch_i.ready  = !in_v_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (cmd_ch_i.ready) begin
      in_v_q <= cmd_ch_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_ch_i.valid && cmd_ch_i.ready) begin
      cmd_q       <= cmd_ch_i.cmd;
      dom_q       <= cmd_ch_i.domain;
      user_mask_q <= cmd_ch_i.user_mask;
      levels_q    <= cmd_ch_i.sense_levels;
    end
  end

  // ---------------- domain state ----------------
  logic [UserW-1:0]     user_bits_q [DomSlots];
  logic [UserW-1:0]     user_bits_d [DomSlots];
  logic [DomSlots-1:0]  fault_q, fault_d;
  logic [MaskW-1:0]     enable_q, enable_d;
  logic [MaskW-1:0]     released_q, released_d;
  pds_pkg::phase_e      phase_q, phase_d;
  logic [DomW-1:0]      seq_dom_q, seq_dom_d;
  logic [UserW-1:0]     seq_user_q, seq_user_d;
  logic [CntW-1:0]      phase_cnt_q, phase_cnt_d;
  logic [CntW-1:0]      waited_q, waited_d;

  // ---------------- command handling ----------------
  logic [UserW-1:0]  user;
  logic              dom_exists;
  logic              do_check;
  logic              rail_up;
  logic [CntW-1:0]   cnt_inc;
  logic [TickW-1:0]  poll_step;
  logic [CntW:0]     waited_sum;
  logic [UserW-1:0]  ub_sel;
  logic [MaskW-1:0]  on_bits;

  logic                       res_v;
  pds_pkg::status_e           res_status;
  logic [DomW-1:0]            res_dom;
  logic                       res_alert;

  always_comb begin
    // user bits beyond the port width read as zero
    for (int i = 0; i < UserW; i++) begin
      user[i] = (i < PortUW) ? user_mask_q[i % PortUW] : 1'b0;
    end

    dom_exists = (int'(dom_q) < pds_pkg::NumDomains) && domain_present_q[dom_q];
    ub_sel     = user_bits_q[dom_q];
    cnt_inc    = (phase_cnt_q < pds_pkg::CntMax) ? phase_cnt_q + 1'b1 : phase_cnt_q;
    poll_step  = (poll_ticks_q == '0) ? TickW'(1) : poll_ticks_q;
    waited_sum = {1'b0, waited_q} + (CntW + 1)'(poll_step);

    user_bits_d = user_bits_q;
    fault_d     = fault_q;
    enable_d    = enable_q;
    released_d  = released_q;
    phase_d     = phase_q;
    seq_dom_d   = seq_dom_q;
    seq_user_d  = seq_user_q;
    phase_cnt_d = phase_cnt_q;
    waited_d    = waited_q;
    do_check    = 1'b0;
    res_v       = 1'b0;
    res_status  = pds_pkg::ST_OK;
    res_dom     = dom_q;
    res_alert   = 1'b0;
    rail_up     = 1'b0;

    if (fire) begin
      unique case (pds_pkg::cmd_e'(cmd_q))
        pds_pkg::CMD_TICK: begin
          priority if (phase_q == pds_pkg::PH_SETTLE) begin
            phase_cnt_d = cnt_inc;
            if (cnt_inc >= CntW'(settle_ticks_q)) begin
              waited_d = '0;
              do_check = 1'b1;
            end
          end else if (phase_q == pds_pkg::PH_POLL) begin
            phase_cnt_d = cnt_inc;
            if (cnt_inc >= CntW'(poll_step)) begin
              phase_cnt_d = '0;
              waited_d    = waited_sum[CntW] ? pds_pkg::CntMax : waited_sum[CntW-1:0];
              do_check    = 1'b1;
            end
          end else begin
          end
        end
        pds_pkg::CMD_REQUEST, pds_pkg::CMD_RELEASE: begin
          res_v = 1'b1;
          priority if (phase_q != pds_pkg::PH_IDLE) begin
            res_status = pds_pkg::ST_BUSY;
          end else if (pds_pkg::cmd_e'(cmd_q) == pds_pkg::CMD_REQUEST) begin
            priority if (!dom_exists || user == '0 || (ub_sel & user) != '0) begin
              // nothing to do
            end else if (ub_sel != '0) begin
              user_bits_d[dom_q] = ub_sel | user;     // joins a rail already up
            end else begin
              // first user: power the rail and start the settle wait
              released_d[dom_q] = 1'b1;
              enable_d[dom_q]   = 1'b1;
              seq_dom_d         = dom_q;
              seq_user_d        = user;
              phase_cnt_d       = '0;
              waited_d          = '0;
              phase_d           = pds_pkg::PH_SETTLE;
              res_v             = 1'b0;
              do_check          = (settle_ticks_q == '0);
            end
          end else begin
            if (dom_exists && (ub_sel & user) != '0) begin
              user_bits_d[dom_q] = ub_sel & ~user;
              if ((ub_sel & ~user) == '0) begin
                released_d[dom_q] = 1'b0;
                if (dom_q == pds_pkg::DomAux && aux_drop_parks_k_q &&
                    int'(pds_pkg::DomK) < pds_pkg::NumDomains) begin
                  released_d[pds_pkg::DomK] = 1'b0;
                end
                enable_d[dom_q] = 1'b0;
              end
            end
          end
        end
        pds_pkg::CMD_NONE: ;
        default: ;
      endcase

      // sense check on the sequenced domain
      if (do_check) begin
        rail_up = ((levels_q ^ sense_up_level_q) & sense_present_q &
                   pds_pkg::sense_mask(seq_dom_d)) == '0;
        res_dom = seq_dom_d;
        priority if (rail_up) begin
          fault_d[seq_dom_d]     = 1'b0;
          user_bits_d[seq_dom_d] = user_bits_d[seq_dom_d] | seq_user_d;
          phase_d                = pds_pkg::PH_IDLE;
          res_v                  = 1'b1;
          res_status             = pds_pkg::ST_OK;
        end else if (waited_d >= timeout_ticks_q) begin
          res_alert              = !fault_q[seq_dom_d];
          released_d[seq_dom_d]  = 1'b0;
          enable_d[seq_dom_d]    = 1'b0;
          fault_d[seq_dom_d]     = 1'b1;
          phase_d                = pds_pkg::PH_IDLE;
          res_v                  = 1'b1;
          res_status             = pds_pkg::ST_FAIL;
        end else begin
          phase_d     = pds_pkg::PH_POLL;
          phase_cnt_d = '0;
        end
      end
    end

    // domains present with at least one user, after this command
    for (int d = 0; d < MaskW; d++) begin
      on_bits[d] = (d < pds_pkg::NumDomains) && domain_present_q[d] &&
                   (user_bits_d[d % DomSlots] != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int d = 0; d < DomSlots; d++) begin
        user_bits_q[d] <= '0;
      end
      fault_q     <= '0;
      enable_q    <= '0;
      released_q  <= '0;
      phase_q     <= pds_pkg::PH_IDLE;
      seq_dom_q   <= '0;
      seq_user_q  <= '0;
      phase_cnt_q <= '0;
      waited_q    <= '0;
    end else begin
      user_bits_q <= user_bits_d;
      fault_q     <= fault_d;
      enable_q    <= enable_d;
      released_q  <= released_d;
      phase_q     <= phase_d;
      seq_dom_q   <= seq_dom_d;
      seq_user_q  <= seq_user_d;
      phase_cnt_q <= phase_cnt_d;
      waited_q    <= waited_d;
    end
  end

  // ---------------- response register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (fire && res_v) begin
      out_v_q <= 1'b1;
    end else if (rsp_ch_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res_v) begin
      rsp_ch_o.status        <= res_status;
      rsp_ch_o.done_domain   <= res_dom;
      rsp_ch_o.enable_mask   <= enable_d;
      rsp_ch_o.released_mask <= released_d;
      rsp_ch_o.on_mask       <= on_bits;
      rsp_ch_o.fault_alert   <= res_alert;
    end
  end

  assign rsp_ch_o.valid = out_v_q;

  // ---------------- assertions ----------------
  // A domain with users always has its enable raised.
  for (genvar g = 0; g < DomSlots; g++) begin : g_user_en_chk
    if (g < MaskW) begin : g_in
      a_users_enabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
        (user_bits_q[g] != '0) |-> enable_q[g])
        else $error("domain has users with enable low");
    end
  end

  // While a sequence is pending its rail is enabled.
  a_seq_enabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != pds_pkg::PH_IDLE) |-> enable_q[seq_dom_q])
    else $error("pending sequence on a disabled rail");

  // A fault alert only rides on a failure response.
  a_alert_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && res_v && res_alert) |=>
      (rsp_ch_o.status == pds_pkg::ST_FAIL && fault_q[rsp_ch_o.done_domain]))
    else $error("fault alert without latched failure");

endmodule

// ===== tb/tb_power_domain_sequencer.sv =====
// ----------------------------------------------------------------------------
// tb_power_domain_sequencer
// Self-checking bench for the power-domain sequencer.
//
// A directed table walks reset answers, busy, failure with and without the
// alert, joins, releases, AUX dropping K, absent domains, zero settle and
// zero poll. Random phases follow under several register settings and
// handshake idling profiles. Every accepted command runs through a local
// rail predictor; every response transfer is compared field by field with
// the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_power_domain_sequencer;
  import pds_pkg::*;

  // Cycles of silence on both channels before the run is declared hung.
  // Longest legal quiet stretch is the receiver hold-off plus a register
  // update, so this leaves a wide margin.
  localparam int WatchdogLimit = 2000;
  // Cycles to let a command with no response clear the two-stage pipe
  localparam int IdleGap       = 4;
  localparam int HoldOffCycles = 64;
  // Index past the register list; writes to it must be ignored
  localparam logic [CfgIdxW-1:0] CfgUnused = 3'd7;

  typedef struct packed {
    cmd_e                  cmd;
    logic [DomW-1:0]       dom;
    logic [UserMaskW-1:0]  user;
    logic [SenseW-1:0]     lv;
  } cmd_item_t;

  typedef struct packed {
    status_e               status;
    logic [DomW-1:0]       dom;
    logic [DomMaskW-1:0]   en;
    logic [DomMaskW-1:0]   rel;
    logic [DomMaskW-1:0]   on;
    logic                  alert;
  } rsp_t;

  // One row of the directed table: either a register write or a command,
  // the latter optionally with a hand-written response
  typedef struct {
    bit                    is_reg;
    logic [CfgIdxW-1:0]    idx;
    logic [CfgDataW-1:0]   val;
    cmd_item_t             item;
    bit                    typed;
    rsp_t                  want;
  } dir_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CfgIdxW-1:0]    cfg_idx;
  logic [CfgDataW-1:0]   cfg_wdata;

  pds_cmd_if cmd_ch ();
  pds_rsp_if rsp_ch ();

  power_domain_sequencer u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .cmd_ch_i    (cmd_ch),
    .rsp_ch_o    (rsp_ch)
  );

  // --------------------------------------------------------------------------
  // Rail predictor: register copies and domain state
  // --------------------------------------------------------------------------
  logic [DomMaskW-1:0]   reg_present;
  logic [SenseW-1:0]     reg_sense_en;
  logic [SenseW-1:0]     reg_sense_up;
  logic [TickW-1:0]      reg_settle;
  logic [TickW-1:0]      reg_poll;
  logic [CntW-1:0]       reg_timeout;
  logic                  reg_aux_k;

  logic [UserMaskW-1:0]  dom_users [NumDomains];
  logic                  dom_fault [NumDomains];
  logic [DomMaskW-1:0]   en_bits;
  logic [DomMaskW-1:0]   rel_bits;
  phase_e                seq_phase;
  logic [DomW-1:0]       seq_dom;
  logic [UserMaskW-1:0]  seq_users;
  logic [CntW-1:0]       tick_cnt;
  logic [CntW-1:0]       wait_cnt;

  rsp_t rsp_due [$];   // predicted responses, oldest first

  int n_bad      = 0;
  int n_cmds     = 0;
  int n_rsps     = 0;
  int n_fails    = 0;
  int n_busy     = 0;
  int n_settings = 0;

  int snd_idle_pct  = 0;
  int rcv_stall_pct = 0;
  bit rsp_hold      = 1'b0;
  int quiet_cycles  = 0;

  function automatic logic [DomMaskW-1:0] powered_mask();
    logic [DomMaskW-1:0] m;
    m = '0;
    for (int d = 0; d < NumDomains; d++)
      if (reg_present[d] && dom_users[d] != '0) m[d] = 1'b1;
    return m;
  endfunction

  function automatic rsp_t make_rsp(status_e st, logic [DomW-1:0] d, logic alert);
    rsp_t r;
    r.status = st;
    r.dom    = d;
    r.en     = en_bits;
    r.rel    = rel_bits;
    r.on     = powered_mask();
    r.alert  = alert;
    return r;
  endfunction

  // Every attached sense line of the domain must read its up level
  function automatic bit rail_is_up(logic [DomW-1:0] d, logic [SenseW-1:0] lv);
    int b;
    for (int s = 0; s < SensePerDomain; s++) begin
      b = int'(d) * SensePerDomain + s;
      if (b < SenseW && reg_sense_en[b] && lv[b] != reg_sense_up[b]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Sense check of the sequenced domain; ends the sequence on up or timeout
  function automatic bit probe_rail(logic [SenseW-1:0] lv, output rsp_t r);
    logic [DomW-1:0] d;
    logic            alert;
    d = seq_dom;
    r = '0;
    if (rail_is_up(d, lv)) begin
      dom_fault[d] = 1'b0;
      dom_users[d] |= seq_users;
      seq_phase    = PH_IDLE;
      r = make_rsp(ST_OK, d, 1'b0);
      return 1'b1;
    end
    if (wait_cnt >= reg_timeout) begin
      alert        = !dom_fault[d];
      rel_bits[d]  = 1'b0;
      en_bits[d]   = 1'b0;
      dom_fault[d] = 1'b1;
      seq_phase    = PH_IDLE;
      r = make_rsp(ST_FAIL, d, alert);
      return 1'b1;
    end
    seq_phase = PH_POLL;
    tick_cnt  = '0;
    return 1'b0;
  endfunction

  // Applies one command to the predictor; returns 1 when it answers
  function automatic bit advance_rails(cmd_item_t c, output rsp_t r);
    logic [CntW-1:0] step;
    int              w;
    r = '0;
    if (c.cmd == CMD_NONE) return 1'b0;
    if (c.cmd == CMD_TICK) begin
      if (seq_phase == PH_SETTLE) begin
        if (tick_cnt != CntMax) tick_cnt++;
        if (tick_cnt >= reg_settle) begin
          wait_cnt = '0;
          return probe_rail(c.lv, r);
        end
      end else if (seq_phase == PH_POLL) begin
        // a zero poll interval behaves as one tick
        step = (reg_poll == '0) ? CntW'(1) : CntW'(reg_poll);
        if (tick_cnt != CntMax) tick_cnt++;
        if (tick_cnt >= step) begin
          tick_cnt = '0;
          w = int'(wait_cnt) + int'(step);
          if (w > int'(CntMax)) w = int'(CntMax);
          wait_cnt = CntW'(w);
          return probe_rail(c.lv, r);
        end
      end
      return 1'b0;
    end
    if (seq_phase != PH_IDLE) begin
      r = make_rsp(ST_BUSY, c.dom, 1'b0);
      return 1'b1;
    end
    if (c.cmd == CMD_REQUEST) begin
      if (!reg_present[c.dom] || c.user == '0 || (dom_users[c.dom] & c.user) != '0) begin
        r = make_rsp(ST_OK, c.dom, 1'b0);
        return 1'b1;
      end
      if (dom_users[c.dom] != '0) begin
        dom_users[c.dom] |= c.user;
        r = make_rsp(ST_OK, c.dom, 1'b0);
        return 1'b1;
      end
      rel_bits[c.dom] = 1'b1;
      en_bits[c.dom]  = 1'b1;
      seq_dom   = c.dom;
      seq_users = c.user;
      tick_cnt  = '0;
      wait_cnt  = '0;
      seq_phase = PH_SETTLE;
      if (reg_settle == '0) return probe_rail(c.lv, r);
      return 1'b0;
    end
    // release
    if (reg_present[c.dom] && (dom_users[c.dom] & c.user) != '0) begin
      dom_users[c.dom] &= ~c.user;
      if (dom_users[c.dom] == '0) begin
        rel_bits[c.dom] = 1'b0;
        if (c.dom == DomAux && reg_aux_k) rel_bits[DomK] = 1'b0;
        en_bits[c.dom] = 1'b0;
      end
    end
    r = make_rsp(ST_OK, c.dom, 1'b0);
    return 1'b1;
  endfunction

  function automatic void apply_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] v);
    case (idx)
      CFG_DOMAIN_PRESENT:   reg_present  = v[DomMaskW-1:0];
      CFG_SENSE_PRESENT:    reg_sense_en = v[SenseW-1:0];
      CFG_SENSE_UP_LEVEL:   reg_sense_up = v[SenseW-1:0];
      CFG_SETTLE_TICKS:     reg_settle   = v[TickW-1:0];
      CFG_POLL_TICKS:       reg_poll     = v[TickW-1:0];
      CFG_TIMEOUT_TICKS:    reg_timeout  = v[CntW-1:0];
      CFG_AUX_DROP_PARKS_K: reg_aux_k    = v[0];
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Random command source, shaped by the predictor state: while a sequence
  // is pending it is mostly ticks, with a few busy commands mixed in.
  // up_pct == 0 makes every sense reading miss the up level.
  // --------------------------------------------------------------------------
  function automatic cmd_item_t pick_cmd(int up_pct);
    cmd_item_t c;
    int        roll;
    int        sub;
    c.dom  = DomW'($urandom_range(NumDomains - 1));
    c.user = UserMaskW'($urandom);
    if (up_pct == 0) c.lv = ~reg_sense_up;
    else if ($urandom_range(99) < up_pct) c.lv = reg_sense_up;
    else c.lv = SenseW'($urandom);
    roll = $urandom_range(99);
    if (roll < 3) begin
      c.cmd = CMD_NONE;
    end else if (seq_phase != PH_IDLE) begin
      c.cmd = (roll < 92) ? CMD_TICK : ((roll < 96) ? CMD_REQUEST : CMD_RELEASE);
    end else if (roll < 45) begin
      c.cmd = CMD_REQUEST;
      sub = $urandom_range(19);
      if (sub < 14) c.user = UserMaskW'(1) << $urandom_range(UserMaskW - 1);
      else if (sub == 19) c.user = '0;
    end else if (roll < 75) begin
      c.cmd = CMD_RELEASE;
      if (dom_users[c.dom] != '0 && $urandom_range(3) != 0) begin
        c.user = dom_users[c.dom] & c.user;
        if (c.user == '0) c.user = dom_users[c.dom];
      end
    end else begin
      c.cmd = CMD_TICK;
    end
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Command driver. Called right after a rising edge; returns at the edge
  // of the transfer with valid still high, so back-to-back items keep it up.
  // --------------------------------------------------------------------------
  task automatic issue_cmd(cmd_item_t c, bit typed, rsp_t want);
    rsp_t r;
    bit   has;
    while ($urandom_range(99) < snd_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_ch.valid        <= 1'b1;
    cmd_ch.cmd          <= c.cmd;
    cmd_ch.domain       <= c.dom;
    cmd_ch.user_mask    <= c.user;
    cmd_ch.sense_levels <= c.lv;
    do @(posedge clk_i); while (!(cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1));
    has = advance_rails(c, r);
    n_cmds++;
    if (typed) rsp_due.push_back(want);
    else if (has) rsp_due.push_back(r);
  endtask

  // Finish any pending sequence with up-level ticks, then let the pipe drain
  task automatic wait_idle();
    cmd_item_t c;
    rsp_t      none;
    none = '0;
    while (seq_phase != PH_IDLE) begin
      c.cmd  = CMD_TICK;
      c.dom  = '0;
      c.user = '0;
      c.lv   = reg_sense_up;
      issue_cmd(c, 1'b0, none);
    end
    cmd_ch.valid <= 1'b0;
    while (rsp_due.size() != 0) @(posedge clk_i);
    repeat (IdleGap) @(posedge clk_i);
  endtask

  // One register write; the caller lowers the write enable afterwards
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v;
    @(posedge clk_i);
    apply_reg(idx, v);
  endtask

  task automatic run_phase(int snd, int rcv, int n_items, int up_pct,
                           logic [CfgDataW-1:0] pres, logic [CfgDataW-1:0] sen,
                           logic [CfgDataW-1:0] upl, logic [CfgDataW-1:0] stl,
                           logic [CfgDataW-1:0] pol, logic [CfgDataW-1:0] tmo,
                           logic [CfgDataW-1:0] auxk, bit hold_off);
    rsp_t none;
    none = '0;
    wait_idle();
    write_reg(CFG_DOMAIN_PRESENT, pres);
    write_reg(CFG_SENSE_PRESENT, sen);
    write_reg(CFG_SENSE_UP_LEVEL, upl);
    write_reg(CFG_SETTLE_TICKS, stl);
    write_reg(CFG_POLL_TICKS, pol);
    write_reg(CFG_TIMEOUT_TICKS, tmo);
    write_reg(CFG_AUX_DROP_PARKS_K, auxk);
    cfg_we        <= 1'b0;
    snd_idle_pct  = snd;
    rcv_stall_pct <= rcv;
    @(posedge clk_i);
    n_settings++;
    // Long receiver hold-off while commands keep coming: the pipe fills and
    // the command channel has to stall.
    if (hold_off) begin
      fork
        begin
          rsp_hold <= 1'b1;
          repeat (HoldOffCycles) @(posedge clk_i);
          rsp_hold <= 1'b0;
        end
      join_none
    end
    repeat (n_items) issue_cmd(pick_cmd(up_pct), 1'b0, none);
  endtask

  // Directed table rows
  function automatic dir_row_t row_c(cmd_e cmd, logic [DomW-1:0] d,
                                     logic [UserMaskW-1:0] u, logic [SenseW-1:0] lv);
    dir_row_t r;
    r.is_reg = 1'b0;
    r.idx    = '0;
    r.val    = '0;
    r.item   = '{cmd: cmd, dom: d, user: u, lv: lv};
    r.typed  = 1'b0;
    r.want   = '0;
    return r;
  endfunction

  function automatic dir_row_t row_t(cmd_e cmd, logic [DomW-1:0] d,
                                     logic [UserMaskW-1:0] u, logic [SenseW-1:0] lv,
                                     status_e st, logic [DomW-1:0] rd,
                                     logic [DomMaskW-1:0] en, logic [DomMaskW-1:0] rel,
                                     logic [DomMaskW-1:0] on, logic alert);
    dir_row_t r;
    r       = row_c(cmd, d, u, lv);
    r.typed = 1'b1;
    r.want  = '{status: st, dom: rd, en: en, rel: rel, on: on, alert: alert};
    return r;
  endfunction

  function automatic dir_row_t row_w(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] v);
    dir_row_t r;
    r        = row_c(CMD_NONE, '0, '0, '0);
    r.is_reg = 1'b1;
    r.idx    = idx;
    r.val    = v;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Clock, receiver, response checker, watchdog
  // --------------------------------------------------------------------------
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (!rst_ni || rsp_hold) rsp_ch.ready <= 1'b0;
    else rsp_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
  end

  task automatic cmp_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      n_bad++;
    end
  endtask

  always @(posedge clk_i) begin : rsp_check
    rsp_t want;
    if (rst_ni && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (rsp_due.size() == 0) begin
        $error("response transfer with nothing predicted (status %0h, domain %0h)",
               rsp_ch.status, rsp_ch.done_domain);
        n_bad++;
      end else begin
        want = rsp_due.pop_front();
        n_rsps++;
        if (want.status == ST_FAIL) n_fails++;
        if (want.status == ST_BUSY) n_busy++;
        cmp_field("status", int'(want.status), int'(rsp_ch.status));
        cmp_field("done_domain", int'(want.dom), int'(rsp_ch.done_domain));
        cmp_field("enable_mask", int'(want.en), int'(rsp_ch.enable_mask));
        cmp_field("released_mask", int'(want.rel), int'(rsp_ch.released_mask));
        cmp_field("on_mask", int'(want.on), int'(rsp_ch.on_mask));
        cmp_field("fault_alert", int'(want.alert), int'(rsp_ch.fault_alert));
      end
    end
  end

  // Counts cycles with no transfer on either channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
        $display("watchdog: no transfer for %0d cycles, %0d responses outstanding",
                 quiet_cycles, rsp_due.size());
        $display("** power_domain_sequencer: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main
    dir_row_t dir_tab [$];

    rst_ni              = 1'b0;
    cfg_we              = 1'b0;
    cfg_idx             = '0;
    cfg_wdata           = '0;
    cmd_ch.valid        = 1'b0;
    cmd_ch.cmd          = CMD_NONE;
    cmd_ch.domain       = '0;
    cmd_ch.user_mask    = '0;
    cmd_ch.sense_levels = '0;

    // predictor reset state mirrors the register reset values
    reg_present  = DomainPresentRst;
    reg_sense_en = SensePresentRst;
    reg_sense_up = SenseUpLevelRst;
    reg_settle   = SettleTicksRst;
    reg_poll     = PollTicksRst;
    reg_timeout  = TimeoutTicksRst;
    reg_aux_k    = AuxDropParksKRst;
    for (int d = 0; d < NumDomains; d++) begin
      dom_users[d] = '0;
      dom_fault[d] = 1'b0;
    end
    en_bits   = '0;
    rel_bits  = '0;
    seq_phase = PH_IDLE;
    seq_dom   = '0;
    seq_users = '0;
    tick_cnt  = '0;
    wait_cnt  = '0;

    // Directed table. Hand-written responses only where they are obvious:
    // straight after reset, busy and failure codes, simple mask changes.
    // answers straight after reset: release of nothing, empty request mask
    dir_tab.push_back(row_t(CMD_RELEASE, 2'd0, 8'h01, 8'h00, ST_OK, 2'd0, 4'h0, 4'h0, 4'h0, 1'b0));
    dir_tab.push_back(row_t(CMD_REQUEST, 2'd2, 8'h00, 8'h00, ST_OK, 2'd2, 4'h0, 4'h0, 4'h0, 1'b0));
    // unused command code: no response
    dir_tab.push_back(row_c(CMD_NONE, 2'd3, 8'hFF, 8'hFF));
    // one-tick settle, zero timeout, OBD sense lines attached
    dir_tab.push_back(row_w(CFG_SETTLE_TICKS, 10'd1));
    dir_tab.push_back(row_w(CFG_TIMEOUT_TICKS, 10'd0));
    dir_tab.push_back(row_w(CFG_SENSE_PRESENT, 10'h0C));
    dir_tab.push_back(row_w(CFG_SENSE_UP_LEVEL, 10'hFF));
    dir_tab.push_back(row_c(CMD_REQUEST, 2'd1, 8'h80, 8'h00));
    // commands during the pending request answer busy with their own domain
    dir_tab.push_back(row_t(CMD_REQUEST, 2'd0, 8'h01, 8'h00, ST_BUSY, 2'd0, 4'h2, 4'h2, 4'h0, 1'b0));
    dir_tab.push_back(row_t(CMD_RELEASE, 2'd3, 8'hFF, 8'h00, ST_BUSY, 2'd3, 4'h2, 4'h2, 4'h0, 1'b0));
    // rail stays down: fail with alert, then again without
    dir_tab.push_back(row_t(CMD_TICK, 2'd0, 8'h00, 8'h00, ST_FAIL, 2'd1, 4'h0, 4'h0, 4'h0, 1'b1));
    dir_tab.push_back(row_c(CMD_REQUEST, 2'd1, 8'h80, 8'h00));
    dir_tab.push_back(row_t(CMD_TICK, 2'd2, 8'h5A, 8'h00, ST_FAIL, 2'd1, 4'h0, 4'h0, 4'h0, 1'b0));
    // zero settle: the request itself checks the sense lines
    dir_tab.push_back(row_w(CFG_SETTLE_TICKS, 10'd0));
    dir_tab.push_back(row_t(CMD_REQUEST, 2'd1, 8'h80, 8'hFF, ST_OK, 2'd1, 4'h2, 4'h2, 4'h2, 1'b0));
    // second user joins, then asks again while already holding the rail
    dir_tab.push_back(row_t(CMD_REQUEST, 2'd1, 8'h01, 8'h00, ST_OK, 2'd1, 4'h2, 4'h2, 4'h2, 1'b0));
    dir_tab.push_back(row_t(CMD_REQUEST, 2'd1, 8'h01, 8'h00, ST_OK, 2'd1, 4'h2, 4'h2, 4'h2, 1'b0));
    dir_tab.push_back(row_c(CMD_RELEASE, 2'd1, 8'h80, 8'h00));
    dir_tab.push_back(row_c(CMD_RELEASE, 2'd1, 8'h40, 8'h00));
    // AUX drop parks K; a write past the register list changes nothing
    dir_tab.push_back(row_w(CFG_AUX_DROP_PARKS_K, 10'd1));
    dir_tab.push_back(row_w(CfgUnused, 10'h3FF));
    dir_tab.push_back(row_c(CMD_REQUEST, 2'd3, 8'hFF, 8'h00));
    dir_tab.push_back(row_c(CMD_REQUEST, 2'd0, 8'h01, 8'h00));
    dir_tab.push_back(row_t(CMD_RELEASE, 2'd0, 8'h01, 8'h00, ST_OK, 2'd0, 4'hA, 4'h2, 4'hA, 1'b0));
    // absent domains: K, then none at all
    dir_tab.push_back(row_w(CFG_DOMAIN_PRESENT, 10'h7));
    dir_tab.push_back(row_t(CMD_RELEASE, 2'd3, 8'hFF, 8'h00, ST_OK, 2'd3, 4'hA, 4'h2, 4'h2, 1'b0));
    dir_tab.push_back(row_c(CMD_REQUEST, 2'd3, 8'h01, 8'h00));
    dir_tab.push_back(row_w(CFG_DOMAIN_PRESENT, 10'h0));
    dir_tab.push_back(row_t(CMD_RELEASE, 2'd1, 8'h01, 8'h00, ST_OK, 2'd1, 4'hA, 4'h2, 4'h0, 1'b0));
    // zero poll interval runs as one tick; all sense lines, up level low
    dir_tab.push_back(row_w(CFG_DOMAIN_PRESENT, 10'hF));
    dir_tab.push_back(row_w(CFG_POLL_TICKS, 10'd0));
    dir_tab.push_back(row_w(CFG_SETTLE_TICKS, 10'd2));
    dir_tab.push_back(row_w(CFG_TIMEOUT_TICKS, 10'd2));
    dir_tab.push_back(row_w(CFG_SENSE_PRESENT, 10'hFF));
    dir_tab.push_back(row_w(CFG_SENSE_UP_LEVEL, 10'h00));
    dir_tab.push_back(row_c(CMD_REQUEST, 2'd2, 8'h10, 8'hFF));
    dir_tab.push_back(row_c(CMD_TICK, 2'd0, 8'h00, 8'hFF));
    dir_tab.push_back(row_c(CMD_TICK, 2'd0, 8'h00, 8'hFF));
    dir_tab.push_back(row_c(CMD_TICK, 2'd0, 8'h00, 8'hFF));
    dir_tab.push_back(row_c(CMD_TICK, 2'd0, 8'h00, 8'h00));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_reg) begin
        wait_idle();
        write_reg(dir_tab[i].idx, dir_tab[i].val);
        cfg_we <= 1'b0;
        @(posedge clk_i);
      end else begin
        issue_cmd(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);
      end
    end
    n_settings++;

    // Random phases: sender idle %, receiver stall %, items, sense-up %,
    // then present, sense present, up level, settle, poll, timeout, AUX->K, hold-off.
    run_phase(0, 0, 140, 30, 10'hF, CfgDataW'($urandom_range(255)),
              CfgDataW'($urandom_range(255)),
              10'd4, 10'd2, 10'd10, 10'd0, 1'b1);
    run_phase(57, 0, 140, 50, CfgDataW'($urandom_range(15)), 10'hFF, 10'h00,
              10'd0, 10'd0, 10'd0, 10'd1, 1'b0);
    run_phase(0, 57, 140, 25, 10'hF, CfgDataW'($urandom_range(255)),
              CfgDataW'($urandom_range(255)),
              10'd1, 10'd1, 10'd3, 10'd0, 1'b0);
    run_phase(20, 20, 140, 30, 10'h5, 10'h00, CfgDataW'($urandom_range(255)),
              10'd2, 10'd3, 10'd9, 10'd1, 1'b0);
    // Long settle and poll with a rail that never comes up: every sequence
    // runs out its timeout and fails.
    run_phase(0, 0, 150, 0, 10'hF, 10'hFF, CfgDataW'($urandom_range(255)),
              10'd20, 10'd7, 10'd60, 10'd0, 1'b0);
    run_phase(57, 0, 160, 40, CfgDataW'($urandom_range(15)),
              CfgDataW'($urandom_range(255)), CfgDataW'($urandom_range(255)),
              CfgDataW'($urandom_range(6)), CfgDataW'($urandom_range(4)),
              CfgDataW'($urandom_range(20)), CfgDataW'($urandom_range(1)),
              1'b0);
    run_phase(0, 57, 160, 40, CfgDataW'($urandom_range(15)),
              CfgDataW'($urandom_range(255)), CfgDataW'($urandom_range(255)),
              CfgDataW'($urandom_range(6)), CfgDataW'($urandom_range(4)),
              CfgDataW'($urandom_range(20)), CfgDataW'($urandom_range(1)),
              1'b0);
    run_phase(20, 20, 160, 35, 10'hF, 10'h55, 10'hAA,
              CfgDataW'(SettleTicksRst), CfgDataW'(PollTicksRst),
              CfgDataW'(TimeoutTicksRst), CfgDataW'(AuxDropParksKRst), 1'b0);

    wait_idle();
    repeat (8) @(posedge clk_i);

    $display("run covered %0d commands over %0d register settings", n_cmds, n_settings);
    $display("%0d responses checked, %0d rail failures, %0d busy answers",
             n_rsps, n_fails, n_busy);
    if (n_bad == 0) begin
      $display("** power_domain_sequencer: PASSED **");
    end else begin
      $display("** power_domain_sequencer: FAILED **");
    end
    $finish;
  end

endmodule
